// ===== rtl/core/tjkp_pkg.sv =====
package tjkp_pkg;

    // Sizes
    localparam int WORD_W           = 32;
    localparam int STATE_WORDS      = 4;
    localparam int KEY_WORDS        = 8;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_IDX_W        = 3;
    localparam int KEY_IDX_W        = $clog2(KEY_WORDS);
    localparam int ROUND_UNITS_DEF  = 8;

    // Key length codes; the reserved code acts as the 256-bit key
    localparam logic [1:0] KS_128   = 2'd0;
    localparam logic [1:0] KS_192   = 2'd1;
    localparam logic [1:0] KS_256   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_01   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_23   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_45   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_67   = 3'd4;

    // Feedback tap shifts (taps 47, 70, 85, 91 above the updated word)
    localparam int T47_LO = 15;
    localparam int T47_HI = 17;
    localparam int T70_LO = 6;
    localparam int T70_HI = 26;
    localparam int T85_LO = 21;
    localparam int T85_HI = 11;
    localparam int T91_LO = 27;
    localparam int T91_HI = 5;

    typedef logic [WORD_W-1:0]                  t_word;
    typedef logic [STATE_WORDS-1:0][WORD_W-1:0] t_state;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0]   t_key;

    // Nonlinear feedback over 32 rounds at once
    function automatic t_word jambu_feedback(t_word a, t_word b, t_word c);
        t_word t47;
        t_word t70;
        t_word t85;
        t_word t91;
        t47 = (a >> T47_LO) | (b << T47_HI);
        t70 = (b >> T70_LO) | (c << T70_HI);
        t85 = (b >> T85_LO) | (c << T85_HI);
        t91 = (b >> T91_LO) | (c << T91_HI);
        return t47 ^ (t70 & t85) ^ t91;
    endfunction

    // One word step: update word k of the state
    function automatic t_state jambu_word_step(t_state s, logic [1:0] k, t_word key);
        t_state r;
        r    = s;
        r[k] = s[k] ^ jambu_feedback(s[k + 2'd1], s[k + 2'd2], s[k + 2'd3]) ^ key;
        return r;
    endfunction

endpackage

// ===== rtl/core/tjkp_if.sv =====
interface tjkp_state_if
    import tjkp_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word state_word_0;
    t_word state_word_1;
    t_word state_word_2;
    t_word state_word_3;

    modport source (output valid, output state_word_0, output state_word_1,
                    output state_word_2, output state_word_3, input ready);
    modport sink   (input valid, input state_word_0, input state_word_1,
                    input state_word_2, input state_word_3, output ready);
endinterface

interface tjkp_perm_if
    import tjkp_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word permuted_word_0;
    t_word permuted_word_1;
    t_word permuted_word_2;
    t_word permuted_word_3;

    modport source (output valid, output permuted_word_0, output permuted_word_1,
                    output permuted_word_2, output permuted_word_3, input ready);
    modport sink   (input valid, input permuted_word_0, input permuted_word_1,
                    input permuted_word_2, input permuted_word_3, output ready);
endinterface

// ===== rtl/core/tinyjambu_keyed_permutation.sv =====
// Channel   | Dir | Handshake     | Payload
// ----------+-----+---------------+-------------------------------------------
// i_state   | in  | valid/ready   | state_word_0..3, 32 bits each
// o_perm    | out | valid/ready   | permuted_word_0..3, 32 bits each
// i_cfg_*   | in  | write enable  | i_cfg_idx (register), i_cfg_data (64 bits)
//
// One stage per round unit (four word steps, 128 rounds): ROUND_UNITS stages.
// One item is taken every cycle while the input channel is ready (a full, stalled pipeline blocks it).
// The last stage register drives o_perm; each stage moves on its own ready,
// so empty stages fill even while the output is stalled.
// Synchronous active-low reset clears valid bits and configuration.
module tinyjambu_keyed_permutation
    import tjkp_pkg::*;
#(
    parameter int ROUND_UNITS = ROUND_UNITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tjkp_state_if.sink            i_state,
    tjkp_perm_if.source           o_perm,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [1:0]             r_key_size;
    t_key                   r_key;

    logic [ROUND_UNITS-1:0] r_vld;
    t_state                 r_state [ROUND_UNITS];
    t_state                 n_state [ROUND_UNITS];
    t_state                 w_in    [ROUND_UNITS];
    logic [ROUND_UNITS-1:0] w_in_vld;
    logic [ROUND_UNITS-1:0] w_rdy;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= KS_128;
            r_key      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_SIZE: r_key_size <= i_cfg_data[1:0];
                CFG_KEY_01:   r_key[1:0] <= i_cfg_data;
                CFG_KEY_23:   r_key[3:2] <= i_cfg_data;
                CFG_KEY_45:   r_key[5:4] <= i_cfg_data;
                CFG_KEY_67:   r_key[7:6] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input side
    assign i_state.ready = w_rdy[0];

    // Output side: last stage register
    assign o_perm.valid           = r_vld[ROUND_UNITS-1];
    assign o_perm.permuted_word_0 = r_state[ROUND_UNITS-1][0];
    assign o_perm.permuted_word_1 = r_state[ROUND_UNITS-1][1];
    assign o_perm.permuted_word_2 = r_state[ROUND_UNITS-1][2];
    assign o_perm.permuted_word_3 = r_state[ROUND_UNITS-1][3];

    for (genvar u = 0; u < ROUND_UNITS; u++) begin : g_stage
        t_state w_mid [STATE_WORDS+1];

        // Feed from the input channel or the previous stage
        if (u == 0) begin : g_first
            assign w_in[u]     = {i_state.state_word_3, i_state.state_word_2,
                                  i_state.state_word_1, i_state.state_word_0};
            assign w_in_vld[u] = i_state.valid;
        end else begin : g_next
            assign w_in[u]     = r_state[u-1];
            assign w_in_vld[u] = r_vld[u-1];
        end

        // Ready ripples back from the output
        if (u == ROUND_UNITS - 1) begin : g_last
            assign w_rdy[u] = !r_vld[u] || o_perm.ready;
        end else begin : g_mid
            assign w_rdy[u] = !r_vld[u] || w_rdy[u+1];
        end

        assign w_mid[0] = w_in[u];

        // Four word steps, key index chosen by key length
        for (genvar t = 0; t < STATE_WORDS; t++) begin : g_step
            localparam int J = STATE_WORDS * u + t;
            localparam logic [KEY_IDX_W-1:0] K4 = KEY_IDX_W'(J % 4);
            localparam logic [KEY_IDX_W-1:0] K6 = KEY_IDX_W'(J % 6);
            localparam logic [KEY_IDX_W-1:0] K8 = KEY_IDX_W'(J % 8);
            t_word w_key;

            assign w_key = (r_key_size == KS_128) ? r_key[K4] :
                           (r_key_size == KS_192) ? r_key[K6] : r_key[K8];
            assign w_mid[t+1] = jambu_word_step(w_mid[t], 2'(t), w_key);
        end

        assign n_state[u] = w_mid[STATE_WORDS];

        // Advance valid bit; hold while stalled
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[u] <= 1'b0;
            end else if (w_rdy[u]) begin
                r_vld[u] <= w_in_vld[u];
            end
        end

        // Load payload on transfer
        always_ff @(posedge i_clk) begin
            if (w_rdy[u] && w_in_vld[u]) begin
                r_state[u] <= n_state[u];
            end
        end
    end

`ifndef SYNTHESIS
    // A stalled stage keeps its item
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        |(r_vld & ~w_rdy) |=> ((r_vld & $past(r_vld & ~w_rdy)) == $past(r_vld & ~w_rdy)))
        else $error("stalled stage lost its item");

    // A held output does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_perm.valid && !o_perm.ready) |=> (o_perm.valid && $stable(r_state[ROUND_UNITS-1])))
        else $error("output changed while stalled");

    // Any empty stage lets the input in
    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_vld) |-> i_state.ready)
        else $error("input blocked with an empty stage");

    // Key size changes only by a write
    a_cfg_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_we |=> $stable(r_key_size))
        else $error("key size changed without a write");
`endif

endmodule
